FILE: rtl/tsg_pkg.sv
package tsg_pkg;

  // Item opcodes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_ADDR  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_TURBO = 2'd1;
  localparam logic [1:0] CFG_ACB   = 2'd2;
  localparam logic [1:0] CFG_MONO  = 2'd3;

  // Mode value that holds every chip in reset.
  localparam logic [1:0] MODE_HELD = 2'd3;

  // Register numbers with special behavior.
  localparam logic [3:0] REG_MIXER = 4'd7;
  localparam logic [3:0] REG_SHAPE = 4'd13;
  localparam logic [3:0] REG_PORTA = 4'd14;
  localparam logic [3:0] REG_PORTB = 4'd15;

  typedef logic [15:0][7:0] regs_t;

  // Register file row after reset: all zero but the mixer register.
  localparam regs_t REGS_RESET = 128'h0000_0000_0000_0000_FF00_0000_0000_0000;

  typedef struct packed {
    logic [4:0] lvl;
    logic       up;
    logic       fr;
  } env_t;

  typedef struct packed {
    logic [2:0][11:0] tone_cnt;
    logic [2:0]       tone_ph;
    logic             nz_pre;
    logic [4:0]       nz_cnt;
    logic [16:0]      lfsr;
    logic [15:0]      env_cnt;
    env_t             env;
  } gen_t;

  // Per-chip control handed to the update stage.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic [4:0] latch;
    logic [1:0] mode;
    logic       turbo;
    logic       acb;
    logic       mono;
    logic [1:0] pan;
    logic       is_sel;
  } chip_ctl_t;

  // Counters wrap at period - 1, or at zero for periods zero and one.
  function automatic logic [15:0] cmp_of(input logic [15:0] period);
    return (period[15:1] != 15'd0) ? period - 16'd1 : 16'd0;
  endfunction

  function automatic logic [15:0] vol_ym(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0: v = 16'd0;      5'd1: v = 16'd257;    5'd2: v = 16'd257;    5'd3: v = 16'd514;
      5'd4: v = 16'd514;    5'd5: v = 16'd771;    5'd6: v = 16'd771;    5'd7: v = 16'd1028;
      5'd8: v = 16'd1542;   5'd9: v = 16'd1799;   5'd10: v = 16'd2313;  5'd11: v = 16'd2570;
      5'd12: v = 16'd3084;  5'd13: v = 16'd3598;  5'd14: v = 16'd4369;  5'd15: v = 16'd4883;
      5'd16: v = 16'd5911;  5'd17: v = 16'd6939;  5'd18: v = 16'd8224;  5'd19: v = 16'd9509;
      5'd20: v = 16'd11308; 5'd21: v = 16'd13621; 5'd22: v = 16'd15934; 5'd23: v = 16'd18247;
      5'd24: v = 16'd21588; 5'd25: v = 16'd26214; 5'd26: v = 16'd30583; 5'd27: v = 16'd34952;
      5'd28: v = 16'd41377; 5'd29: v = 16'd49344; 5'd30: v = 16'd57568; default: v = 16'd65535;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] vol_ay(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0: v = 16'd0;      4'd1: v = 16'd771;    4'd2: v = 16'd1028;   4'd3: v = 16'd1542;
      4'd4: v = 16'd2570;   4'd5: v = 16'd3855;   4'd6: v = 16'd5397;   4'd7: v = 16'd8738;
      4'd8: v = 16'd10280;  4'd9: v = 16'd16705;  4'd10: v = 16'd23387; 4'd11: v = 16'd29298;
      4'd12: v = 16'd37008; 4'd13: v = 16'd46517; 4'd14: v = 16'd55255; default: v = 16'd65535;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] ay_mask(input logic [3:0] i);
    logic [7:0] m;
    case (i)
      4'd1, 4'd3, 4'd5, 4'd13:  m = 8'h0f;
      4'd6, 4'd8, 4'd9, 4'd10:  m = 8'h1f;
      default:                  m = 8'hff;
    endcase
    return m;
  endfunction

  // One step of the envelope shape machine.
  function automatic env_t env_step(input logic [7:0] shape, input env_t e);
    env_t o;
    logic zero, ones, bot, botp1, topm1, top, fr, up;
    zero  = (e.lvl[4:1] == 4'd0);
    ones  = (e.lvl[4:1] == 4'hf);
    bot   = zero && !e.lvl[0];
    botp1 = zero && e.lvl[0];
    topm1 = ones && !e.lvl[0];
    top   = ones && e.lvl[0];
    fr    = e.fr;
    up    = e.up;
    o.lvl = e.lvl;
    if (!e.fr) begin
      o.lvl = e.up ? e.lvl + 5'd1 : e.lvl - 5'd1;
    end
    if (!shape[3]) begin
      if (e.up ? top : botp1) fr = 1'b1;
    end else if (shape[0]) begin
      if (!e.up) begin
        if (shape[1] ? bot : botp1) fr = 1'b1;
      end else if (shape[1] ? top : topm1) begin
        fr = 1'b1;
      end
    end else if (shape[1]) begin
      if (!e.up) begin
        if (botp1) fr = 1'b1;
        if (bot) begin
          fr = 1'b0;
          up = 1'b1;
        end
      end else begin
        if (topm1) fr = 1'b1;
        if (top) begin
          fr = 1'b0;
          up = 1'b0;
        end
      end
    end
    o.fr = fr;
    o.up = up;
    return o;
  endfunction

endpackage

FILE: rtl/tsg_ram.sv
module tsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/tsg_chip_update.sv
module tsg_chip_update (
  input  tsg_pkg::regs_t     regs_i,
  input  tsg_pkg::gen_t      gen_i,
  input  tsg_pkg::chip_ctl_t ctl,
  output tsg_pkg::regs_t     regs_o,
  output tsg_pkg::gen_t      gen_o,
  output logic [7:0]         rd_o,
  output logic [17:0]        left_o,
  output logic [17:0]        right_o
);

  logic             held, ay, do_tick, do_wr, env_go;
  logic [3:0]       idx;
  logic [11:0]      per;
  logic [15:0]      env_per;
  logic [16:0]      p;
  tsg_pkg::env_t    env_src;
  logic [4:0]       lvl [3];
  logic [15:0]      vol [3];
  logic [17:0]      sum_l, sum_r;

  assign held    = (ctl.mode == tsg_pkg::MODE_HELD);
  assign ay      = ctl.mode[0];
  assign do_tick = (ctl.op == tsg_pkg::OP_TICK) && !held;
  assign do_wr   = (ctl.op == tsg_pkg::OP_WRITE) && !held && ctl.is_sel && !ctl.latch[4];
  assign idx     = ctl.latch[3:0];

  // Register write, counters, LFSR and envelope.
  always_comb begin
    regs_o  = regs_i;
    gen_o   = gen_i;
    env_go  = 1'b0;
    env_src = gen_i.env;
    per     = 12'd0;
    env_per = 16'd0;
    p       = gen_i.lfsr;
    if (do_wr) begin
      regs_o[idx] = ctl.data;
      if (idx == tsg_pkg::REG_SHAPE) begin
        gen_o.env_cnt = 16'd0;
        env_src.lvl   = ctl.data[2] ? 5'd0 : 5'd31;
        env_src.up    = ctl.data[2];
        env_src.fr    = 1'b0;
        env_go        = 1'b1;
      end
    end
    if (do_tick) begin
      for (int ch = 0; ch < 3; ch++) begin
        per = {regs_i[2*ch+1][3:0], regs_i[2*ch]};
        if ({4'd0, gen_i.tone_cnt[ch]} >= tsg_pkg::cmp_of({4'd0, per})) begin
          gen_o.tone_cnt[ch] = 12'd0;
          gen_o.tone_ph[ch]  = !gen_i.tone_ph[ch];
        end else begin
          gen_o.tone_cnt[ch] = gen_i.tone_cnt[ch] + 12'd1;
        end
      end
      gen_o.nz_pre = !gen_i.nz_pre;
      if (gen_i.nz_pre) begin
        if ({11'd0, gen_i.nz_cnt} >= tsg_pkg::cmp_of({11'd0, regs_i[6][4:0]})) begin
          gen_o.nz_cnt = 5'd0;
          gen_o.lfsr   = {p[0] ^ p[2] ^ (p == 17'd0), p[16:1]};
        end else begin
          gen_o.nz_cnt = gen_i.nz_cnt + 5'd1;
        end
      end
      env_per = {regs_i[12], regs_i[11]};
      if (gen_i.env_cnt >= tsg_pkg::cmp_of(env_per)) begin
        gen_o.env_cnt = 16'd0;
        env_go        = 1'b1;
      end else begin
        gen_o.env_cnt = gen_i.env_cnt + 16'd1;
      end
    end
    if (env_go) begin
      gen_o.env = tsg_pkg::env_step(regs_o[tsg_pkg::REG_SHAPE], env_src);
    end
  end

  // Register read.
  always_comb begin
    rd_o = 8'd0;
    if ((ctl.op == tsg_pkg::OP_READ) && ctl.is_sel) begin
      if (ctl.latch[4] && !ay) begin
        rd_o = 8'hff;
      end else if (idx == tsg_pkg::REG_PORTA) begin
        rd_o = regs_i[tsg_pkg::REG_MIXER][6] ? regs_i[idx] : 8'hff;
      end else if (idx == tsg_pkg::REG_PORTB) begin
        rd_o = regs_i[tsg_pkg::REG_MIXER][7] ? regs_i[idx] : 8'hff;
      end else begin
        rd_o = ay ? (regs_i[idx] & tsg_pkg::ay_mask(idx)) : regs_i[idx];
      end
    end
  end

  // Channel levels after this item, through the volume tables.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      lvl[ch] = 5'd0;
      if (!held &&
          (regs_o[tsg_pkg::REG_MIXER][ch] | gen_o.tone_ph[ch]) &&
          (regs_o[tsg_pkg::REG_MIXER][ch+3] | gen_o.lfsr[0])) begin
        if (regs_o[8+ch][4]) begin
          lvl[ch] = gen_o.env.lvl;
        end else if (regs_o[8+ch][3:0] != 4'd0) begin
          lvl[ch] = {regs_o[8+ch][3:0], 1'b1};
        end
      end
      vol[ch] = ay ? tsg_pkg::vol_ay(lvl[ch][4:1]) : tsg_pkg::vol_ym(lvl[ch]);
    end
  end

  // Stereo mix of this chip.
  always_comb begin
    if (ctl.mono) begin
      sum_l = 18'(vol[0]) + 18'(vol[1]) + 18'(vol[2]);
      sum_r = sum_l;
    end else begin
      sum_l = 18'(vol[0]) + (ctl.acb ? 18'(vol[2]) : 18'(vol[1]));
      sum_r = 18'(vol[1]) + 18'(vol[2]);
    end
    left_o  = ((ctl.turbo || ctl.is_sel) && ctl.pan[1]) ? sum_l : 18'd0;
    right_o = ((ctl.turbo || ctl.is_sel) && ctl.pan[0]) ? sum_r : 18'd0;
  end

endmodule

FILE: rtl/triple_psg_sound_generator.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall    in_opcode, in_data_byte
// out      output     out_valid / out_stall  out_read_data, out_left_level, out_right_level
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// The sequencer reads one chip row of an item from the register and generator memories
// per cycle, and the update stage writes each row back in the following cycle. An item's
// result moves from the update stage to the output buffer; up to two items are in flight.
// Reset is synchronous; it clears all control state and marks every memory row as unwritten.
// A stalled output holds in a two-entry buffer; the input stalls at two items in flight.
module triple_psg_sound_generator #(
  parameter int NUM_CHIPS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [19:0] out_left_level,
  output logic [19:0] out_right_level,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);

  localparam int CW = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
  localparam int GW = $bits(tsg_pkg::gen_t);
  localparam int RW = $bits(tsg_pkg::regs_t);

  // Configuration and bus state.
  logic [1:0]  mode_r;
  logic        turbo_r, acb_r;
  logic [2:0]  mono_r;
  logic [1:0]  sel_r;
  logic [1:0]  pan_r   [NUM_CHIPS];
  logic [4:0]  latch_r [NUM_CHIPS];

  // Sequencer.
  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]    item_op_r;
  logic [7:0]    item_data_r;
  logic          last_issue, accept, pop, push;
  logic [1:0]    occ_r;
  logic [1:0]    pick;

  // Update stage.
  logic               s2_valid_r, s2_last_r;
  logic [CW-1:0]      s2_chip_r;
  tsg_pkg::chip_ctl_t s2_ctl_r, ctl_issue;
  logic [NUM_CHIPS-1:0] vreg_r, vgen_r;
  logic               fwd_v_r;
  logic [CW-1:0]      fwd_chip_r;
  tsg_pkg::regs_t     fwd_regs_r, regs_cur, regs_new;
  tsg_pkg::gen_t      fwd_gen_r, gen_cur, gen_new;
  logic [RW-1:0]      ram_q_regs;
  logic [GW-1:0]      ram_q_gen;
  logic               fwd_hit;
  logic [7:0]         cu_rd, acc_rd_r, sum_rd;
  logic [17:0]        cu_left, cu_right;
  logic [19:0]        acc_l_r, acc_rr_r, sum_l, sum_r;

  // Output buffer.
  logic [7:0]  fifo_rd_r [2];
  logic [19:0] fifo_l_r  [2];
  logic [19:0] fifo_r_r  [2];
  logic        wp_r, rp_r;
  logic [1:0]  fcnt_r;

  assign last_issue = busy_r && (cnt_r == CW'(NUM_CHIPS - 1));
  assign in_stall   = !((!busy_r || last_issue) && (occ_r != 2'd2));
  assign accept     = in_valid && !in_stall;
  assign out_valid  = (fcnt_r != 2'd0);
  assign pop        = out_valid && !out_stall;
  assign push       = s2_valid_r && s2_last_r;
  assign pick       = (in_data_byte[1:0] == 2'd2) ? 2'd1 :
                      ((in_data_byte[1:0] == 2'd1) ? 2'd2 : 2'd0);

  // Control handed to the update stage for the chip being read.
  always_comb begin
    ctl_issue.op     = item_op_r;
    ctl_issue.data   = item_data_r;
    ctl_issue.latch  = latch_r[sel_r[CW-1:0]];
    ctl_issue.mode   = mode_r;
    ctl_issue.turbo  = turbo_r;
    ctl_issue.acb    = acb_r;
    ctl_issue.mono   = mono_r[cnt_r];
    ctl_issue.pan    = pan_r[cnt_r];
    ctl_issue.is_sel = (sel_r == 2'(cnt_r));
  end

  // Configuration writes, address selects and the chip sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 2'd0;
      turbo_r <= 1'b0;
      acb_r   <= 1'b0;
      mono_r  <= 3'd0;
      sel_r   <= 2'd0;
      for (int c = 0; c < NUM_CHIPS; c++) begin
        pan_r[c]   <= 2'd3;
        latch_r[c] <= 5'd0;
      end
      busy_r     <= 1'b0;
      cnt_r      <= '0;
      s2_valid_r <= 1'b0;
      vreg_r     <= '0;
      vgen_r     <= '0;
      fwd_v_r    <= 1'b0;
      occ_r      <= 2'd0;
      fcnt_r     <= 2'd0;
      wp_r       <= 1'b0;
      rp_r       <= 1'b0;
    end else begin
      if (accept && (mode_r != tsg_pkg::MODE_HELD) && (in_opcode == tsg_pkg::OP_ADDR)) begin
        if (in_data_byte[7] && (in_data_byte[4:2] == 3'b111)) begin
          if (turbo_r && (32'(pick) < NUM_CHIPS)) begin
            sel_r               <= pick;
            pan_r[pick[CW-1:0]] <= in_data_byte[6:5];
          end
        end else if (in_data_byte[7:5] == 3'd0) begin
          latch_r[sel_r[CW-1:0]] <= in_data_byte[4:0];
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          tsg_pkg::CFG_MODE: begin
            mode_r <= cfg_data[1:0];
            if (cfg_data[1:0] == tsg_pkg::MODE_HELD) begin
              sel_r   <= 2'd0;
              vreg_r  <= '0;
              fwd_v_r <= 1'b0;
              for (int c = 0; c < NUM_CHIPS; c++) begin
                pan_r[c]   <= 2'd3;
                latch_r[c] <= 5'd0;
              end
            end
          end
          tsg_pkg::CFG_TURBO: turbo_r <= cfg_data[0];
          tsg_pkg::CFG_ACB:   acb_r   <= cfg_data[0];
          tsg_pkg::CFG_MONO:  mono_r  <= cfg_data;
          default: ;
        endcase
      end
      // Sequencer: one chip row read per cycle.
      if (accept) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (last_issue) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
      end
      s2_valid_r <= busy_r;
      // Written rows become valid; the last write is kept for forwarding.
      if (s2_valid_r) begin
        vreg_r[s2_chip_r] <= 1'b1;
        vgen_r[s2_chip_r] <= 1'b1;
      end
      if (!(cfg_we && (cfg_index == tsg_pkg::CFG_MODE)
            && (cfg_data[1:0] == tsg_pkg::MODE_HELD))) begin
        fwd_v_r <= s2_valid_r;
      end
      occ_r <= occ_r + 2'(accept) - 2'(pop);
      fcnt_r <= fcnt_r + 2'(push) - 2'(pop);
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
    end
  end

  // Payload registers of the sequencer and update stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_op_r   <= in_opcode;
      item_data_r <= in_data_byte;
    end
    s2_chip_r  <= cnt_r;
    s2_last_r  <= last_issue;
    s2_ctl_r   <= ctl_issue;
    fwd_chip_r <= s2_chip_r;
    fwd_regs_r <= regs_new;
    fwd_gen_r  <= gen_new;
    if (s2_valid_r) begin
      acc_rd_r <= sum_rd;
      acc_l_r  <= sum_l;
      acc_rr_r <= sum_r;
    end
    if (push) begin
      fifo_rd_r[wp_r] <= sum_rd;
      fifo_l_r[wp_r]  <= sum_l;
      fifo_r_r[wp_r]  <= sum_r;
    end
  end

  tsg_ram #(.WIDTH(RW), .DEPTH(NUM_CHIPS)) u_regs_ram (
    .clk   (clk),
    .we    (s2_valid_r),
    .waddr (s2_chip_r),
    .wdata (regs_new),
    .raddr (cnt_r),
    .rdata (ram_q_regs)
  );

  tsg_ram #(.WIDTH(GW), .DEPTH(NUM_CHIPS)) u_gen_ram (
    .clk   (clk),
    .we    (s2_valid_r),
    .waddr (s2_chip_r),
    .wdata (gen_new),
    .raddr (cnt_r),
    .rdata (ram_q_gen)
  );

  // A row written in the cycle it was read comes from the forwarding register.
  assign fwd_hit  = fwd_v_r && (fwd_chip_r == s2_chip_r);
  assign regs_cur = fwd_hit ? fwd_regs_r :
                    (vreg_r[s2_chip_r] ? tsg_pkg::regs_t'(ram_q_regs) : tsg_pkg::REGS_RESET);
  assign gen_cur  = fwd_hit ? fwd_gen_r :
                    (vgen_r[s2_chip_r] ? tsg_pkg::gen_t'(ram_q_gen) : tsg_pkg::gen_t'('0));

  tsg_chip_update u_update (
    .regs_i  (regs_cur),
    .gen_i   (gen_cur),
    .ctl     (s2_ctl_r),
    .regs_o  (regs_new),
    .gen_o   (gen_new),
    .rd_o    (cu_rd),
    .left_o  (cu_left),
    .right_o (cu_right)
  );

  // Accumulate over the chips of one item.
  assign sum_rd = ((s2_chip_r == '0) ? 8'd0 : acc_rd_r) | cu_rd;
  assign sum_l  = ((s2_chip_r == '0) ? 20'd0 : acc_l_r) + 20'(cu_left);
  assign sum_r  = ((s2_chip_r == '0) ? 20'd0 : acc_rr_r) + 20'(cu_right);

  assign out_read_data   = fifo_rd_r[rp_r];
  assign out_left_level  = fifo_l_r[rp_r];
  assign out_right_level = fifo_r_r[rp_r];

  // The output buffer never holds more results than items in flight.
  a_fifo_le_occ: assert property (@(posedge clk) disable iff (!rst_n) fcnt_r <= occ_r)
    else $error("output buffer holds more results than accepted items");
  a_occ_max: assert property (@(posedge clk) disable iff (!rst_n) occ_r != 2'd3)
    else $error("more than two items in flight");
  a_stage_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> s2_valid_r)
    else $error("update stage missed a chip row");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fcnt_r != 2'd2) || pop)
    else $error("result pushed into a full output buffer");

endmodule
